// File: hw/rtl/sst_pkg.sv
// Package for the stop switch state tracker: payload structs, codes, sizes.
// Used by every module in hw/rtl.
`timescale 1ns / 1ps
package sst_pkg;
    localparam int TableDepth = 16;
    localparam int IdxW = $clog2(TableDepth);
    localparam int QDepth = 2;

    localparam logic [1:0] ACT_FRAME = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_LOCAL = 2'd2;
    localparam logic [1:0] ACT_TXOUT = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_WRONG_PORT = 3'd1;
    localparam logic [2:0] ST_BAD_LEN   = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_MISSED    = 3'd4;
    localparam logic [2:0] ST_NOT_SRV   = 3'd5;

    localparam logic [1:0] REG_SERVER  = 2'd0;
    localparam logic [1:0] REG_PORT    = 2'd1;
    localparam logic [1:0] REG_PERIOD  = 2'd2;
    localparam logic [1:0] REG_TIMEOUT = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  rx_port;
        logic [3:0]  rx_length;
        logic [63:0] sender_name;
        logic [7:0]  count_byte;
        logic [7:0]  state_byte;
        logic [1:0]  local_state;
        logic        tx_ok;
    } t_in;

    typedef struct packed {
        logic [2:0] status;
        logic       combined_stop;
        logic       state_changed;
        logic       tx_valid;
        logic [7:0] tx_count;
        logic [7:0] tx_state_byte;
    } t_out;

    // classified command handed from front to back
    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  pre_status;
        logic [63:0] name;
        logic [7:0]  count;
        logic [1:0]  state;
        logic        tx_ok;
    } t_cmd;
endpackage

// File: hw/rtl/sst_front.sv
// Front end: accepts transactions, classifies frames, queues commands.
// Depends on sst_pkg.
`timescale 1ns / 1ps
module sst_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sst_pkg::t_in  i_data,
    input  logic [7:0]    i_local_port,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output sst_pkg::t_cmd o_cmd
);
    import sst_pkg::*;

    t_cmd r_q [QDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd n_cmd;
    logic push, pop;

    always_comb begin
        n_cmd.action     = i_data.action;
        n_cmd.name       = i_data.sender_name;
        n_cmd.count      = i_data.count_byte;
        n_cmd.state      = (i_data.action == ACT_LOCAL) ? i_data.local_state
                                                        : i_data.state_byte[1:0];
        n_cmd.tx_ok      = i_data.tx_ok;
        n_cmd.pre_status = ST_OK;
        if (i_data.action == ACT_FRAME) begin
            if (i_data.rx_port != i_local_port) begin
                n_cmd.pre_status = ST_WRONG_PORT;
            end else if (i_data.rx_length != 4'd8) begin
                n_cmd.pre_status = ST_BAD_LEN;
            end
        end
    end

    assign o_ready     = (r_cnt != 2'(QDepth));
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'(QDepth))
        else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !o_cmd_valid) else $error("valid on empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == $past(r_cnt) + 2'd1)) else $error("count slip");
endmodule

// File: hw/rtl/sst_back.sv
// Back end: table scan sequencer, timers, own state and result register.
// Depends on sst_pkg.
`timescale 1ns / 1ps
module sst_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  sst_pkg::t_cmd i_cmd,
    input  logic          i_server,
    input  logic [15:0]   i_period,
    input  logic [15:0]   i_timeout,
    output logic          o_valid,
    input  logic          i_ready,
    output sst_pkg::t_out o_data
);
    import sst_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_PRUNE = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] r_st;
    t_cmd r_cmd;
    logic [IdxW:0] r_i;
    logic [TableDepth-1:0] r_vld;
    logic [63:0] r_name [TableDepth];
    logic [7:0]  r_ecnt [TableDepth];
    logic [1:0]  r_est  [TableDepth];
    logic [31:0] r_stamp [TableDepth];
    logic [31:0] r_now, r_pstart;
    logic [1:0]  r_own;
    logic [7:0]  r_owncnt;
    logic        r_pend;
    logic        r_hit, r_free_ok, r_before;
    logic [IdxW-1:0] r_slot, r_free;
    logic [2:0]  r_status;
    logic        r_txv;
    logic        r_ovalid;
    t_out        r_out;
    logic [IdxW-1:0] idx;
    logic [TableDepth-1:0] stop_vec;
    logic        any_stop;
    logic        missed;
    logic [7:0]  ocnt;
    logic [31:0] age;

    assign idx = r_i[IdxW-1:0];
    always_comb begin
        for (int k = 0; k < TableDepth; k++) begin
            stop_vec[k] = r_vld[k] && (r_est[k] == 2'd0);
        end
    end
    assign any_stop = (r_own == 2'd0) || (|stop_vec);
    assign ocnt   = r_hit ? r_ecnt[r_slot] : 8'd0;
    assign missed = (ocnt == 8'd255) ? (r_cmd.count != 8'd0)
                                      : ({1'b0, r_cmd.count} > {1'b0, ocnt} + 9'd1);
    assign age    = r_now - r_stamp[idx];

    assign o_cmd_ready = (r_st == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_vld <= '0;
            r_now <= '0;
            r_pstart <= '0;
            r_own <= 2'd1;
            r_owncnt <= '0;
            r_pend <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready && r_st != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        r_status <= i_cmd.pre_status;
                        r_txv <= 1'b0;
                        r_before <= any_stop;
                        r_i <= '0;
                        r_hit <= 1'b0;
                        r_free_ok <= 1'b0;
                        unique case (i_cmd.action)
                            ACT_FRAME: r_st <= (i_cmd.pre_status == ST_OK) ? S_SCAN : S_DONE;
                            ACT_TICK: begin
                                r_now <= r_now + 32'd1;
                                r_st <= ((r_now + 32'd1 - r_pstart) >= {16'd0, i_period})
                                        ? S_PRUNE : S_DONE;
                            end
                            ACT_LOCAL: begin
                                if (!i_server) begin
                                    r_status <= ST_NOT_SRV;
                                end else if (i_cmd.state != r_own) begin
                                    r_own <= i_cmd.state;
                                    r_pend <= 1'b1;
                                end
                                r_st <= S_DONE;
                            end
                            default: begin
                                if (r_pend && i_cmd.tx_ok) begin
                                    r_owncnt <= r_owncnt + 8'd1;
                                    r_pend <= 1'b0;
                                end
                                r_st <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (!r_hit && r_vld[idx] && r_name[idx] == r_cmd.name) begin
                        r_hit <= 1'b1;
                        r_slot <= idx;
                    end
                    if (!r_free_ok && !r_vld[idx]) begin
                        r_free_ok <= 1'b1;
                        r_free <= idx;
                    end
                    if (r_i == (IdxW+1)'(TableDepth - 1)) begin
                        r_st <= S_UPD;
                    end
                    r_i <= r_i + 1'b1;
                end
                S_UPD: begin
                    if (!r_hit && !r_free_ok) begin
                        r_status <= ST_FULL;
                        r_st <= S_DONE;
                    end else if (!r_hit) begin
                        r_hit <= 1'b1;
                        r_slot <= r_free;
                        r_vld[r_free] <= 1'b1;
                        r_name[r_free] <= r_cmd.name;
                        r_ecnt[r_free] <= 8'd0;
                    end else begin
                        r_est[r_slot] <= missed ? 2'd0 : r_cmd.state;
                        r_ecnt[r_slot] <= r_cmd.count;
                        r_stamp[r_slot] <= r_now;
                        r_status <= missed ? ST_MISSED : ST_OK;
                        r_st <= S_DONE;
                    end
                end
                S_PRUNE: begin
                    if (r_i == '0) begin
                        r_pstart <= r_now;
                        if (i_server) begin
                            r_pend <= 1'b1;
                        end
                    end
                    if (r_vld[idx] && age >= {16'd0, i_timeout}) begin
                        r_vld[idx] <= 1'b0;
                    end
                    if (r_i == (IdxW+1)'(TableDepth - 1)) begin
                        r_st <= S_DONE;
                    end
                    r_i <= r_i + 1'b1;
                end
                S_DONE: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_out.status <= r_status;
                        r_out.combined_stop <= any_stop;
                        r_out.state_changed <= (r_cmd.action == ACT_FRAME) &&
                            (r_status == ST_OK || r_status == ST_MISSED) &&
                            (r_before != any_stop);
                        r_out.tx_valid <= (r_cmd.action == ACT_TICK) && r_pend && i_server;
                        r_out.tx_count <= r_owncnt;
                        r_out.tx_state_byte <= {6'b111111, r_own};
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_DONE && (!r_ovalid || i_ready)) |=> r_ovalid) else $error("lost result");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_ready) |=> $stable(r_out)) else $error("result changed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_ready |-> (r_st == S_IDLE)) else $error("ready while busy");
endmodule

// File: hw/rtl/stop_switch_state_tracker.sv
// Stop switch state tracker top: config registers, front queue, back sequencer.
// A non-table item goes from idle straight to the result; a valid frame scans all
// 16 entries, then updates (twice if it inserts); an expiring tick sweeps all 16.
// The back end takes a new item only when idle. Reset (i_rst_n, synchronous): table
// empty, timers zero, own state permit, registers at 0 / 0 / 100 / 300.
`timescale 1ns / 1ps
module stop_switch_state_tracker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sst_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output sst_pkg::t_out o_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data
);
    import sst_pkg::*;

    logic        r_server;
    logic [7:0]  r_port;
    logic [15:0] r_period, r_timeout;
    logic        cmd_valid, cmd_ready;
    t_cmd        cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server  <= 1'b0;
            r_port    <= 8'd0;
            r_period  <= 16'd100;
            r_timeout <= 16'd300;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SERVER:  r_server  <= i_cfg_data[0];
                REG_PORT:    r_port    <= i_cfg_data[7:0];
                REG_PERIOD:  r_period  <= i_cfg_data;
                REG_TIMEOUT: r_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sst_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data,
        .i_local_port(r_port),
        .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready), .o_cmd(cmd)
    );

    sst_back u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready), .i_cmd(cmd),
        .i_server(r_server), .i_period(r_period), .i_timeout(r_timeout),
        .o_valid, .i_ready, .o_data
    );
endmodule

// File: tb/sv/stop_switch_state_tracker_tb.sv
// Testbench for stop_switch_state_tracker: directed and random transactions checked
// against an in-bench model of the switch table. Depends on sst_pkg and the RTL top.
`timescale 1ns / 1ps
module stop_switch_state_tracker_tb;
    import sst_pkg::*;

    localparam int CycleLimit = 1500000;
    localparam int NumNames = 20;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_in i_data = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_out o_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    stop_switch_state_tracker u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model state
    logic [63:0] tbl_name [TableDepth];
    logic        tbl_valid [TableDepth];
    logic [7:0]  tbl_count [TableDepth];
    logic [1:0]  tbl_state [TableDepth];
    logic [31:0] tbl_stamp [TableDepth];
    logic [31:0] m_now, m_pstart;
    logic [1:0]  m_own_state;
    logic [7:0]  m_own_count;
    logic        m_pending;
    logic        r_server;
    logic [7:0]  r_port;
    logic [31:0] r_period, r_timeout;

    t_out expected_results[$];
    int errors = 0;
    int cycles = 0;
    bit idle_rx = 1'b1;
    bit idle_tx = 1'b1;
    int hold_off = 0;
    logic [63:0] names [NumNames];

    function automatic bit any_stop();
        if (m_own_state == 2'd0) return 1'b1;
        for (int i = 0; i < TableDepth; i++)
            if (tbl_valid[i] && tbl_state[i] == 2'd0) return 1'b1;
        return 1'b0;
    endfunction

    function automatic t_out track_step(t_in it);
        t_out r;
        int slot;
        bit prior_stop, missed;
        r = '0;
        r.status = ST_OK;
        case (it.action)
            ACT_FRAME: begin
                if (it.rx_port != r_port) r.status = ST_WRONG_PORT;
                else if (it.rx_length != 4'd8) r.status = ST_BAD_LEN;
                else begin
                    slot = -1;
                    for (int i = 0; i < TableDepth; i++)
                        if (slot < 0 && tbl_valid[i] && tbl_name[i] == it.sender_name) slot = i;
                    prior_stop = any_stop();
                    if (slot < 0) begin
                        for (int i = 0; i < TableDepth; i++)
                            if (slot < 0 && !tbl_valid[i]) slot = i;
                        if (slot >= 0) begin
                            tbl_valid[slot] = 1'b1;
                            tbl_name[slot] = it.sender_name;
                            tbl_count[slot] = 8'd0;
                            tbl_state[slot] = 2'd1;
                        end
                    end
                    if (slot < 0) r.status = ST_FULL;
                    else begin
                        missed = (tbl_count[slot] == 8'd255 && it.count_byte != 8'd0) ||
                                 (tbl_count[slot] != 8'd255 &&
                                  {1'b0, it.count_byte} > {1'b0, tbl_count[slot]} + 9'd1);
                        tbl_state[slot] = missed ? 2'd0 : it.state_byte[1:0];
                        tbl_stamp[slot] = m_now;
                        tbl_count[slot] = it.count_byte;
                        r.state_changed = prior_stop != any_stop();
                        if (missed) r.status = ST_MISSED;
                    end
                end
            end
            ACT_TICK: begin
                m_now = m_now + 32'd1;
                if (m_now - m_pstart >= r_period) begin
                    m_pstart = m_now;
                    for (int i = 0; i < TableDepth; i++)
                        if (tbl_valid[i] && m_now - tbl_stamp[i] >= r_timeout)
                            tbl_valid[i] = 1'b0;
                    if (r_server) m_pending = 1'b1;
                end
                r.tx_valid = m_pending && r_server;
            end
            ACT_LOCAL: begin
                if (!r_server) r.status = ST_NOT_SRV;
                else if (it.local_state != m_own_state) begin
                    m_own_state = it.local_state;
                    m_pending = 1'b1;
                end
            end
            default: begin
                if (m_pending && it.tx_ok) begin
                    m_own_count = m_own_count + 8'd1;
                    m_pending = 1'b0;
                end
            end
        endcase
        r.combined_stop = any_stop();
        r.tx_count = m_own_count;
        r.tx_state_byte = 8'hFC | {6'd0, m_own_state};
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("stop_switch_state_tracker: mismatch");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result %p", $time, o_data);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (o_data.status !== want.status)
                    $display("%0t status exp %0d got %0d", $time, want.status, o_data.status);
                if (o_data.combined_stop !== want.combined_stop)
                    $display("%0t combined_stop exp %0d got %0d", $time,
                             want.combined_stop, o_data.combined_stop);
                if (o_data.state_changed !== want.state_changed)
                    $display("%0t state_changed exp %0d got %0d", $time,
                             want.state_changed, o_data.state_changed);
                if (o_data.tx_valid !== want.tx_valid)
                    $display("%0t tx_valid exp %0d got %0d", $time, want.tx_valid, o_data.tx_valid);
                if (o_data.tx_count !== want.tx_count)
                    $display("%0t tx_count exp %0h got %0h", $time, want.tx_count, o_data.tx_count);
                if (o_data.tx_state_byte !== want.tx_state_byte)
                    $display("%0t tx_state_byte exp %0h got %0h", $time,
                             want.tx_state_byte, o_data.tx_state_byte);
                if (o_data !== want) errors++;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready <= 1'b0;
        end else if (!idle_rx && $urandom_range(0, 7) == 0) begin
            hold_off <= $urandom_range(1, 11);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic send_item(t_in it);
        if (!idle_tx && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_data <= it;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_results.push_back(track_step(it));
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_SERVER:  r_server = val[0];
            REG_PORT:    r_port = val[7:0];
            REG_PERIOD:  r_period = {16'd0, val};
            default:     r_timeout = {16'd0, val};
        endcase
        @(negedge i_clk);
    endtask

    task automatic configure(bit srv, logic [7:0] port, logic [15:0] per, logic [15:0] tmo);
        drain();
        write_reg(REG_SERVER, {15'd0, srv});
        write_reg(REG_PORT, {8'd0, port});
        write_reg(REG_PERIOD, per);
        write_reg(REG_TIMEOUT, tmo);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in make_frame(logic [63:0] nm, logic [7:0] cnt, logic [7:0] st);
        t_in it;
        it = '0;
        it.action = ACT_FRAME;
        it.rx_port = r_port;
        it.rx_length = 4'd8;
        it.sender_name = nm;
        it.count_byte = cnt;
        it.state_byte = st;
        return it;
    endfunction

    function automatic t_in make_op(logic [1:0] act, logic [1:0] ls, logic ok);
        t_in it;
        it = '0;
        it.action = act;
        it.local_state = ls;
        it.tx_ok = ok;
        return it;
    endfunction

    function automatic t_in random_item();
        t_in it;
        int k;
        it = t_in'(97'({$urandom, $urandom, $urandom, $urandom}));
        k = $urandom_range(0, 99);
        if (k < 45) begin
            it = make_frame(names[$urandom_range(0, NumNames - 1)],
                            $urandom_range(0, 5) == 0 ? 8'($urandom) : 8'($urandom_range(0, 3)),
                            8'($urandom));
            if ($urandom_range(0, 9) == 0) it.rx_port = 8'($urandom);
            if ($urandom_range(0, 9) == 0) it.rx_length = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 15) == 0) it.sender_name = {$urandom, $urandom};
        end else if (k < 75) it.action = ACT_TICK;
        else if (k < 88) it.action = ACT_LOCAL;
        else it.action = ACT_TXOUT;
        return it;
    endfunction

    task automatic test_directed();
        configure(1'b0, 8'd0, 16'd1, 16'd65535);
        send_item(make_op(ACT_LOCAL, 2'd0, 1'b0));
        send_item(make_frame(64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 8'hFF));
        send_item(make_frame(64'd0, 8'd1, 8'h00));
        send_item(make_frame(64'd0, 8'd3, 8'h01));
        send_item(make_frame(64'd0, 8'd255, 8'h01));
        send_item(make_frame(64'd0, 8'd1, 8'h01));
        send_item(make_frame(64'd0, 8'd0, 8'h02));
        begin
            t_in it;
            it = make_frame(64'd5, 8'd0, 8'd1);
            it.rx_port = 8'd255;
            send_item(it);
            it = make_frame(64'd5, 8'd0, 8'd1);
            it.rx_length = 4'd15;
            send_item(it);
        end
        send_item(make_op(ACT_TICK, 2'd0, 1'b0));
        configure(1'b1, 8'd255, 16'd2, 16'd1);
        for (int i = 0; i < TableDepth + 1; i++)
            send_item(make_frame({32'hA5A5_0000, i}, 8'd0, 8'd1));
        send_item(make_op(ACT_LOCAL, 2'd0, 1'b0));
        send_item(make_op(ACT_TICK, 2'd0, 1'b0));
        send_item(make_op(ACT_TICK, 2'd0, 1'b0));
        send_item(make_op(ACT_TXOUT, 2'd0, 1'b0));
        send_item(make_op(ACT_TXOUT, 2'd0, 1'b1));
        send_item(make_op(ACT_LOCAL, 2'd3, 1'b0));
    endtask

    task automatic test_random(int n, bit srv, logic [7:0] port, logic [15:0] per,
                               logic [15:0] tmo);
        configure(srv, port, per, tmo);
        for (int i = 0; i < n; i++) send_item(random_item());
    endtask

    task automatic test_backpressure();
        drain();
        @(posedge i_clk);
        hold_off = 400;
        @(negedge i_clk);
        for (int i = 0; i < 12; i++) send_item(random_item());
        drain();
        for (int i = 0; i < 10; i++) send_item(random_item());
    endtask

    initial begin
        for (int i = 0; i < NumNames; i++) names[i] = {$urandom, $urandom};
        for (int i = 0; i < TableDepth; i++) tbl_valid[i] = 1'b0;
        m_now = '0; m_pstart = '0; m_own_state = 2'd1; m_own_count = '0; m_pending = 1'b0;
        r_server = 1'b0; r_port = 8'd0; r_period = 32'd100; r_timeout = 32'd300;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        idle_rx = 1'b0;
        idle_tx = 1'b0;
        test_directed();
        test_random(200, 1'b1, 8'($urandom), 16'd5, 16'd20);
        test_random(150, 1'b0, 8'd7, 16'd3, 16'd9);
        test_backpressure();
        test_random(150, 1'b1, 8'd0, 16'd65535, 16'd65535);
        test_random(150, 1'b1, 8'd0, 16'd1, 16'd2);
        idle_rx = 1'b1;
        idle_tx = 1'b1;
        test_random(150, 1'b1, 8'd3, 16'd4, 16'd12);
        drain();
        if (errors == 0) $display("stop_switch_state_tracker: match");
        else $display("stop_switch_state_tracker: mismatch");
        $finish;
    end
endmodule
